/* sv/pcbp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pcbp_pkg;

  // Fixed field widths of the stream items
  localparam int SYM_W   = 8;
  localparam int CODE_W  = 32;
  localparam int LEN_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int TOTAL_W = 40;

  // Code table geometry
  localparam int TBL_DEPTH = 1 << SYM_W;

  // Bit buffer: up to 7 leftover bits plus one full code, left aligned
  localparam int BUF_W  = CODE_W + BYTE_W;
  localparam int PEND_W = BYTE_W - 1;
  localparam int PCNT_W = 3;
  localparam int NBYTE_W = 3;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_CODE_LEN = 32;
  localparam int DEF_COUNT_WIDTH  = 40;

  // Input item kinds (carried on in_tuser)
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_ENCODE = 2'd1;
  localparam logic [1:0] KIND_FLUSH  = 2'd2;

  // One code table entry
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } tbl_entry_t;

  // Write and read request toward the code table
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [SYM_W-1:0]  addr;
    tbl_entry_t        wr_data;
  } tbl_req_t;

endpackage

`default_nettype wire

/* sv/pcbp_code_table.sv */
`timescale 1ns / 1ps
`default_nettype none

module pcbp_code_table
  import pcbp_pkg::*;
(
  input  wire logic       clk,
  input  wire tbl_req_t   req,
  output tbl_entry_t      rd_data
);

  // 256 x 38 single-port table, registered read
  tbl_entry_t mem [TBL_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule

`default_nettype wire

/* sv/prefix_code_bit_packer_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  tdata (low bit first)                        tuser        tlast
// in_       in   symbol[7:0] code_bits[39:8] code_length[45:40] kind[1:0]    -
// out_      out  data_byte[7:0] total_bits[47:8]               has_byte     last
//
// Load: table write on the accept edge. Kind 3: accepted, no result.
// Encode: accept, table read in S_READ, then one output byte (0..4) per cycle in S_EMIT
//   while the output slot is free; the one-byte output register holds one byte at a time.
// Flush: accept, then S_FLUSH places the result in the output register once the slot is free.
// Reset is synchronous, active low; the code table is not cleared and holds
//   garbage until loaded. A stalled out_tready holds the emit sequence.

module prefix_code_bit_packer_core
  import pcbp_pkg::*;
#(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
  parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // symbol, code_bits, code_length, zero pad
  input  wire logic [1:0]  in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // data_byte, total_bits
  output logic             out_tuser,  // has_byte
  output logic             out_tlast   // last
);

  localparam int EFF_LEN = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_EMIT  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [PEND_W-1:0]    pend_la_r, pend_la_nxt;   // leftover bits, left aligned
  logic [PCNT_W-1:0]    pend_cnt_r, pend_cnt_nxt;
  logic [COUNT_WIDTH-1:0] total_r, total_nxt;
  logic [BUF_W-1:0]     sh_r, sh_nxt;
  logic [NBYTE_W-1:0]   bytes_left_r, bytes_left_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]    out_byte_r, out_byte_nxt;
  logic                 out_has_r, out_has_nxt;
  logic                 out_last_r, out_last_nxt;
  logic [TOTAL_W-1:0]   out_total_r, out_total_nxt;

  logic [SYM_W-1:0]     in_sym;
  logic [CODE_W-1:0]    in_code;
  logic [LEN_W-1:0]     in_len;
  logic [LEN_W-1:0]     ld_len;
  logic [CODE_W-1:0]    ld_code;
  logic                 in_acc;
  logic                 slot_free;
  tbl_req_t             tbl_req;
  tbl_entry_t           tbl_rd;

  logic [CODE_W-1:0]    code_la;
  logic [BUF_W-1:0]     merged;
  logic [LEN_W-1:0]     cnt_sum;
  logic [COUNT_WIDTH:0] tot_sum;
  logic [COUNT_WIDTH-1:0] tot_sat;

  assign in_sym  = in_tdata[7:0];
  assign in_code = in_tdata[39:8];
  assign in_len  = in_tdata[45:40];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // Load path: clamp length and drop stray code bits
  always_comb begin
    ld_len = (in_len > LEN_W'(EFF_LEN)) ? LEN_W'(EFF_LEN) : in_len;
    if (ld_len < LEN_W'(CODE_W)) begin
      ld_code = in_code & CODE_W'((({(CODE_W+1){1'b0}} | (CODE_W+1)'(1)) << ld_len) - 1);
    end else begin
      ld_code = in_code;
    end
  end

  // Table request
  always_comb begin
    tbl_req.wr_en        = in_acc && (in_tuser == KIND_LOAD);
    tbl_req.rd_en        = in_acc && (in_tuser == KIND_ENCODE);
    tbl_req.addr         = in_sym;
    tbl_req.wr_data.len  = ld_len;
    tbl_req.wr_data.code = ld_code;
  end

  pcbp_code_table u_table (
    .clk     (clk),
    .req     (tbl_req),
    .rd_data (tbl_rd)
  );

  // Merge leftover bits with the looked-up code, both left aligned
  always_comb begin
    code_la = tbl_rd.code << (LEN_W'(CODE_W) - tbl_rd.len);
    merged  = {pend_la_r, {(BUF_W-PEND_W){1'b0}}}
            | ({code_la, {BYTE_W{1'b0}}} >> pend_cnt_r);
    cnt_sum = LEN_W'(pend_cnt_r) + tbl_rd.len;
    tot_sum = {1'b0, total_r} + (COUNT_WIDTH+1)'(tbl_rd.len);
    tot_sat = tot_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : tot_sum[COUNT_WIDTH-1:0];
  end

  // Next-state logic
  always_comb begin
    state_nxt      = state_r;
    pend_la_nxt    = pend_la_r;
    pend_cnt_nxt   = pend_cnt_r;
    total_nxt      = total_r;
    sh_nxt         = sh_r;
    bytes_left_nxt = bytes_left_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_byte_nxt   = out_byte_r;
    out_has_nxt    = out_has_r;
    out_last_nxt   = out_last_r;
    out_total_nxt  = out_total_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            KIND_ENCODE: state_nxt = S_READ;
            KIND_FLUSH:  state_nxt = S_FLUSH;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_READ: begin
        if (tbl_rd.len == '0) begin
          state_nxt = S_IDLE;
        end else begin
          total_nxt    = tot_sat;
          pend_cnt_nxt = cnt_sum[PCNT_W-1:0];
          if (cnt_sum[LEN_W-1:PCNT_W] == '0) begin
            pend_la_nxt = merged[BUF_W-1 -: PEND_W];
            state_nxt   = S_IDLE;
          end else begin
            sh_nxt         = merged;
            bytes_left_nxt = cnt_sum[LEN_W-1:PCNT_W];
            state_nxt      = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = sh_r[BUF_W-1 -: BYTE_W];
          out_has_nxt    = 1'b1;
          out_last_nxt   = (bytes_left_r == NBYTE_W'(1));
          out_total_nxt  = TOTAL_W'(total_r);
          sh_nxt         = sh_r << BYTE_W;
          bytes_left_nxt = bytes_left_r - NBYTE_W'(1);
          if (bytes_left_r == NBYTE_W'(1)) begin
            pend_la_nxt = sh_r[BUF_W-BYTE_W-1 -: PEND_W];
            state_nxt   = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_has_nxt   = (pend_cnt_r != '0);
          out_byte_nxt  = (pend_cnt_r != '0) ? {pend_la_r, 1'b0} : '0;
          out_last_nxt  = 1'b1;
          out_total_nxt = TOTAL_W'(total_r);
          pend_la_nxt   = '0;
          pend_cnt_nxt  = '0;
          total_nxt     = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_la_r    <= '0;
      pend_cnt_r   <= '0;
      total_r      <= '0;
      bytes_left_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_la_r    <= pend_la_nxt;
      pend_cnt_r   <= pend_cnt_nxt;
      total_r      <= total_nxt;
      bytes_left_r <= bytes_left_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sh_r        <= sh_nxt;
    out_byte_r  <= out_byte_nxt;
    out_has_r   <= out_has_nxt;
    out_last_r  <= out_last_nxt;
    out_total_r <= out_total_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_total_r, out_byte_r};
  assign out_tuser  = out_has_r;
  assign out_tlast  = out_last_r;

  // Leftover bits are zero when the count is zero outside emit; emit refreshes them on its last byte
  a_pend_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_EMIT && pend_cnt_r == '0) |-> (pend_la_r == '0))
    else $error("leftover bits set with empty buffer");

  // Emit state always has bytes to send
  a_emit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (bytes_left_r != '0))
    else $error("emit with no bytes left");

  // A count-only result is a flush result with a zero byte
  a_count_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_has_r) |-> (out_last_r && (out_byte_r == '0)))
    else $error("count-only result malformed");

  // Flush clears buffer and total
  a_flush_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH && slot_free) |=> (total_r == '0 && pend_cnt_r == '0))
    else $error("flush did not clear state");

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
  import pcbp_pkg::*;

  // Kind code the block ignores
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int CODE_LIMIT   = (DEF_MAX_CODE_LEN < CODE_W) ? DEF_MAX_CODE_LEN : CODE_W;
  localparam logic [40:0] TOTAL_SAT = (41'd1 << DEF_COUNT_WIDTH) - 41'd1;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 170;
  localparam int CYCLE_LIMIT  = 100000;

  // One output transaction as the block should present it
  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic               has_byte;
    logic               last;
    logic [TOTAL_W-1:0] total_bits;
  } packed_out_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  prefix_code_bit_packer_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Shadow copy of the code table and the bit buffer
  logic [CODE_W-1:0]  code_shadow [TBL_DEPTH];
  logic [LEN_W-1:0]   len_shadow  [TBL_DEPTH];
  bit                 entry_loaded[TBL_DEPTH];
  logic [7:0]         loaded_syms[$];
  logic [PEND_W-1:0]  buf_bits = '0;
  logic [PCNT_W-1:0]  buf_count = '0;
  logic [TOTAL_W-1:0] running_total = '0;

  packed_out_t expected_bytes[$];

  // Stimulus controls
  bit quiet_in  = 1'b0;
  bit quiet_out = 1'b0;
  int hold_reqs = 0;

  // Statistics
  int errors = 0;
  int n_loads = 0;
  int n_encodes = 0;
  int n_flushes = 0;
  int n_ignored = 0;
  int n_checked = 0;
  int cycles = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles at %0t", cycles, $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Update the shadow state for one accepted transaction, queue its outputs
  task automatic predict_packed_bytes(input logic [1:0] kind, input logic [7:0] sym,
                                      input logic [CODE_W-1:0] code,
                                      input logic [LEN_W-1:0] len);
    int eff_len;
    int n;
    logic [7:0] acc;
    logic [7:0] widened;
    logic [40:0] sum;
    logic [CODE_W-1:0] cw;
    packed_out_t outs[4];
    packed_out_t r;
    case (kind)
      KIND_LOAD: begin
        n_loads++;
        eff_len = (int'(len) > CODE_LIMIT) ? CODE_LIMIT : int'(len);
        cw = code;
        if (eff_len < 32) cw = code & ((32'd1 << eff_len) - 32'd1);
        code_shadow[sym] = cw;
        len_shadow[sym] = LEN_W'(eff_len);
        if (!entry_loaded[sym]) begin
          entry_loaded[sym] = 1'b1;
          loaded_syms = {loaded_syms, sym};
        end
      end
      KIND_ENCODE: begin
        n_encodes++;
        eff_len = int'(len_shadow[sym]);
        cw = code_shadow[sym];
        n = 0;
        if (eff_len != 0) begin
          sum = {1'b0, running_total} + 41'(eff_len);
          running_total = (sum > TOTAL_SAT) ? TOTAL_SAT[TOTAL_W-1:0] : sum[TOTAL_W-1:0];
          for (int i = eff_len - 1; i >= 0; i--) begin
            acc = {buf_bits, cw[i]};
            if (buf_count == 3'd7) begin
              if (n < 4) begin
                outs[n] = '{data_byte: acc, has_byte: 1'b1, last: 1'b0,
                            total_bits: running_total};
                n++;
              end
              buf_bits = '0;
              buf_count = '0;
            end else begin
              buf_bits = acc[6:0];
              buf_count = buf_count + 3'd1;
            end
          end
          if (n > 0) outs[n-1].last = 1'b1;
          for (int k = 0; k < n; k++) expected_bytes = {expected_bytes, outs[k]};
        end
      end
      KIND_FLUSH: begin
        n_flushes++;
        widened = {1'b0, buf_bits};
        if (buf_count != 0) begin
          r.data_byte = widened << (8 - int'(buf_count));
          r.has_byte = 1'b1;
        end else begin
          r.data_byte = '0;
          r.has_byte = 1'b0;
        end
        r.last = 1'b1;
        r.total_bits = running_total;
        expected_bytes = {expected_bytes, r};
        buf_bits = '0;
        buf_count = '0;
        running_total = '0;
      end
      default: n_ignored++;
    endcase
  endtask

  // Offer one item after a random gap, wait for the accept, then predict
  task automatic send_item(input logic [1:0] kind, input logic [7:0] sym,
                           input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser <= kind;
    in_tdata <= {2'b00, len, code, sym};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_packed_bytes(kind, sym, code, len);
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Receiver: random stall before each result, long hold on request
  initial begin
    int stall;
    int holds_done;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        stall = quiet_out ? 0 : $urandom_range(0, 10);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_tready <= 1'b1;
        do @(posedge clk); while (!(rst_n && out_tvalid && out_tready));
      end
    end
  end

  // Output checker
  packed_out_t want;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_checked++;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected output byte=%h has=%b last=%b total=%0d", $time,
                 out_tdata[7:0], out_tuser, out_tlast, out_tdata[47:8]);
      end else begin
        want = expected_bytes.pop_front();
        if (out_tdata[7:0] !== want.data_byte) begin
          errors++;
          $display("%0t: data_byte expected %h actual %h", $time, want.data_byte,
                   out_tdata[7:0]);
        end
        if (out_tuser !== want.has_byte) begin
          errors++;
          $display("%0t: has_byte expected %b actual %b", $time, want.has_byte, out_tuser);
        end
        if (out_tlast !== want.last) begin
          errors++;
          $display("%0t: last expected %b actual %b", $time, want.last, out_tlast);
        end
        if (out_tdata[47:8] !== want.total_bits) begin
          errors++;
          $display("%0t: total_bits expected %0d actual %0d", $time, want.total_bits,
                   out_tdata[47:8]);
        end
      end
    end
  end

  // Table loads covering clamping, stray bits and field extremes
  task automatic test_table_loads();
    send_item(KIND_LOAD, 8'd0, 32'h0000_0001, 6'd1);
    send_item(KIND_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32);
    send_item(KIND_LOAD, 8'd1, 32'hFFFF_FFFF, 6'd0);     // empty code, bits dropped
    send_item(KIND_LOAD, 8'd2, 32'hA5A5_5A5A, 6'd63);    // clamped to 32
    send_item(KIND_LOAD, 8'd3, 32'h0000_0000, 6'd33);    // clamped, all zero
    send_item(KIND_LOAD, 8'd4, 32'hFFFF_FFF5, 6'd3);     // only 101 kept
    send_item(KIND_LOAD, 8'd5, 32'h0000_006B, 6'd7);
    send_item(KIND_UNUSED, 8'd255, 32'hFFFF_FFFF, 6'd63);
  endtask

  // Encodes and flushes on the loaded entries
  task automatic test_encode_flush();
    send_item(KIND_FLUSH, 8'd0, '0, '0);                 // flush of an empty buffer
    send_item(KIND_ENCODE, 8'd0, '0, '0);                // too few bits for a byte
    send_item(KIND_ENCODE, 8'd1, '0, '0);                // empty code
    send_item(KIND_ENCODE, 8'd255, '0, '0);              // four bytes, one bit left
    send_item(KIND_ENCODE, 8'd5, '0, '0);                // completes a byte
    send_item(KIND_ENCODE, 8'd4, '0, '0);
    send_item(KIND_ENCODE, 8'd2, '0, '0);
    send_item(KIND_ENCODE, 8'd3, '0, '0);
    send_item(KIND_FLUSH, 8'd255, 32'hFFFF_FFFF, 6'd63); // leftover padded
    send_item(KIND_FLUSH, 8'd0, '0, '0);
    send_item(KIND_ENCODE, 8'd255, '0, '0);              // byte aligned code
    send_item(KIND_FLUSH, 8'd0, '0, '0);                 // count only, total 32
  endtask

  // Mostly encodes of loaded symbols, with reloads, flushes and noise
  task automatic test_random_stream();
    int done;
    int pick;
    int sel;
    logic [LEN_W-1:0] len;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      quiet_in = (done >= 60 && done < 90);
      quiet_out = quiet_in;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_item(KIND_UNUSED, 8'($urandom()), $urandom(), 6'($urandom()));
      end else begin
        if (pick < 18) begin
          sel = $urandom_range(0, 9);
          if (sel == 0) len = 6'($urandom_range(33, 63));
          else if (sel == 1) len = 6'd0;
          else len = 6'($urandom_range(1, 32));
          send_item(KIND_LOAD, 8'($urandom()), $urandom(), len);
        end else if (pick < 92) begin
          sel = $urandom_range(0, loaded_syms.size() - 1);
          send_item(KIND_ENCODE, loaded_syms[sel], $urandom(), 6'($urandom()));
        end else begin
          send_item(KIND_FLUSH, 8'($urandom()), $urandom(), 6'($urandom()));
        end
        done++;
      end
    end
    quiet_in = 1'b0;
    quiet_out = 1'b0;
  endtask

  // Receiver holds off while long codes keep coming back to back
  task automatic test_output_backpressure();
    send_item(KIND_LOAD, 8'd255, 32'hC3A5_0F69, 6'd32);
    hold_reqs++;
    quiet_in = 1'b1;
    repeat (20) send_item(KIND_ENCODE, 8'd255, '0, '0);
    send_item(KIND_FLUSH, 8'd0, '0, '0);
    quiet_in = 1'b0;
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_table_loads();
    test_encode_flush();
    test_random_stream();
    test_output_backpressure();
    go_idle();
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d loads, %0d encodes, %0d flushes, %0d ignored items",
             n_loads, n_encodes, n_flushes, n_ignored);
    $display("Checked %0d output transactions, %0d mismatches", n_checked, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* prefix_code_bit_packer_core.f */
sv/pcbp_pkg.sv
sv/pcbp_code_table.sv
sv/prefix_code_bit_packer_core.sv
sim/tb.sv
